### hw/rtl/lcdp_pkg.sv
`default_nettype none

package lcdp_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] ms_t;
	typedef logic [1:0]  kind_t;

	// Item kinds on the result channel.
	localparam kind_t KIND_CMD   = 2'd0;
	localparam kind_t KIND_PARAM = 2'd1;
	localparam kind_t KIND_DELAY = 2'd2;
	localparam kind_t KIND_END   = 2'd3;

	// A command byte of this value opens a delay or end-of-list record.
	localparam byte_t MARK_BYTE   = 8'hFF;
	localparam byte_t SCALE_RESET = 8'd10;

	typedef struct packed {
		kind_t kind;
		byte_t value;
		ms_t   wait_ms;
		logic  last;
	} item_t;

endpackage

`default_nettype wire

### hw/rtl/lcdp_if.sv
`default_nettype none

interface lcdp_byte_if;
	import lcdp_pkg::*;

	logic  valid;
	logic  ready;
	byte_t list_byte;

	modport source (output valid, output list_byte, input ready);
	modport sink (input valid, input list_byte, output ready);
endinterface

interface lcdp_item_if;
	import lcdp_pkg::*;

	logic  valid;
	logic  ready;
	kind_t item_kind;
	byte_t byte_value;
	ms_t   wait_ms;
	logic  last_param;

	modport source (output valid, output item_kind, output byte_value, output wait_ms,
		output last_param, input ready);
	modport sink (input valid, input item_kind, input byte_value, input wait_ms,
		input last_param, output ready);
endinterface

`default_nettype wire

### hw/rtl/lcdp_parser.sv
`default_nettype none

module lcdp_parser (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 take,
	input  wire lcdp_pkg::byte_t list_byte,
	input  wire lcdp_pkg::byte_t scale,
	output logic                has_item,
	output lcdp_pkg::item_t     item
);
	import lcdp_pkg::*;

	localparam logic [1:0] PH_CMD    = 2'd0;
	localparam logic [1:0] PH_COUNT  = 2'd1;
	localparam logic [1:0] PH_PARAM  = 2'd2;
	localparam logic [1:0] PH_PSEUDO = 2'd3;

	logic [1:0] phase_q;
	logic [1:0] phase_nxt;
	byte_t      left_q;
	byte_t      left_nxt;
	ms_t        product;

	assign product = 16'(list_byte) * 16'(scale);

	always_comb begin
		phase_nxt = phase_q;
		left_nxt  = left_q;
		has_item  = 1'b0;
		item      = '{kind: KIND_CMD, value: '0, wait_ms: '0, last: 1'b0};
		case (phase_q)
			PH_CMD: begin
				if (list_byte == MARK_BYTE) begin
					phase_nxt = PH_PSEUDO;
				end else begin
					phase_nxt  = PH_COUNT;
					has_item   = 1'b1;
					item.value = list_byte;
				end
			end
			PH_COUNT: begin
				left_nxt  = list_byte;
				phase_nxt = (list_byte == '0) ? PH_CMD : PH_PARAM;
			end
			PH_PARAM: begin
				has_item   = 1'b1;
				item.kind  = KIND_PARAM;
				item.value = list_byte;
				if (left_q <= 8'd1) begin
					left_nxt  = '0;
					phase_nxt = PH_CMD;
					item.last = 1'b1;
				end else begin
					left_nxt = left_q - 8'd1;
				end
			end
			default: begin
				phase_nxt = PH_CMD;
				has_item  = 1'b1;
				if (list_byte == MARK_BYTE) begin
					item.kind = KIND_END;
				end else begin
					item.kind    = KIND_DELAY;
					item.wait_ms = product;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			left_q  <= '0;
		end else if (take) begin
			phase_q <= phase_nxt;
			left_q  <= left_nxt;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/lcd_init_command_list_player_core.sv
`default_nettype none

// Channel    Dir  Payload                                        Beat when
// list_in    in   list_byte                                      valid && ready
// items      out  item_kind, byte_value, wait_ms, last_param     valid && ready
// cfg        in   cfg_wdata (delay_scale_ms)                     cfg_we
//
// One list byte is taken per cycle while list_in.ready is high. A byte is held in
// the input register, decoded against the parser state, and its result (if any)
// is written to the output register once that register is free or being emptied.
// Reset clears both stage valids, the parser state and sets the scale to 10 ms.
// A stall on items holds the output register and with it the input register;
// list_in.ready then stays high only while the input register is empty.

module lcd_init_command_list_player_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire lcdp_pkg::byte_t cfg_wdata,
	lcdp_byte_if.sink            list_in,
	lcdp_item_if.source          items
);
	import lcdp_pkg::*;

	// Delay scale; users must write it only while the block is idle (not enforced).
	byte_t scale_q;

	// Input register stage.
	logic  valid_s1;
	byte_t byte_s1;

	// Output register stage.
	logic  valid_s2;
	item_t item_s2;

	logic  s1_go;
	logic  s1_fire;
	logic  has_item;
	item_t item;

	// The input stage moves on whenever the output register is free or is being
	// emptied this cycle; bytes that make no item move on as well.
	assign s1_go          = !valid_s2 || items.ready;
	assign s1_fire        = valid_s1 && s1_go;
	assign list_in.ready  = !valid_s1 || s1_go;

	lcdp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (s1_fire),
		.list_byte(byte_s1),
		.scale    (scale_q),
		.has_item (has_item),
		.item     (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (list_in.ready) begin
			valid_s1 <= list_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (list_in.ready && list_in.valid) begin
			byte_s1 <= list_in.list_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_fire) begin
			valid_s2 <= has_item;
		end else if (items.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_item) begin
			item_s2 <= item;
		end
	end

	assign items.valid      = valid_s2;
	assign items.item_kind  = item_s2.kind;
	assign items.byte_value = item_s2.value;
	assign items.wait_ms    = item_s2.wait_ms;
	assign items.last_param = item_s2.last;

endmodule

`default_nettype wire

### test/tb.sv
module tb;
	import lcdp_pkg::*;

	// Shadow copy of the parser phase; its encoding is private to the testbench.
	typedef enum logic [1:0] {
		AWAIT_CMD,
		AWAIT_COUNT,
		IN_PARAMS,
		AWAIT_ARG
	} parse_phase_e;

	// One row of the directed list. A row with pinned set carries an item whose
	// value is obvious from the list format alone; every other row relies on
	// the shadow parser for its expectation.
	typedef struct packed {
		byte_t b;
		logic  pinned;
		item_t want;
	} list_row_t;

	localparam item_t NO_ITEM = '0;
	localparam int DIRECTED_ROWS = 24;
	localparam int PHASE_BYTES = 280;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	// Directed list, played with the reset scale of 10 ms. It covers a zero
	// count, a single parameter of 0xFF, a three-parameter record, delays with
	// arguments 0, 0xFE and 1, an end marker followed by a fresh list, and 0xFF
	// used as an ordinary parameter byte.
	localparam list_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h00, 1'b1, '{KIND_CMD, 8'h00, 16'd0, 1'b0}},
		'{8'h00, 1'b0, NO_ITEM},
		'{8'hFE, 1'b1, '{KIND_CMD, 8'hFE, 16'd0, 1'b0}},
		'{8'h01, 1'b0, NO_ITEM},
		'{8'hFF, 1'b1, '{KIND_PARAM, 8'hFF, 16'd0, 1'b1}},
		'{8'h2A, 1'b0, NO_ITEM},
		'{8'h03, 1'b0, NO_ITEM},
		'{8'h00, 1'b0, NO_ITEM},
		'{8'h80, 1'b0, NO_ITEM},
		'{8'h7F, 1'b0, NO_ITEM},
		'{8'hFF, 1'b0, NO_ITEM},
		'{8'h00, 1'b1, '{KIND_DELAY, 8'h00, 16'd0, 1'b0}},
		'{8'hFF, 1'b0, NO_ITEM},
		'{8'hFE, 1'b1, '{KIND_DELAY, 8'h00, 16'd2540, 1'b0}},
		'{8'hFF, 1'b0, NO_ITEM},
		'{8'h01, 1'b1, '{KIND_DELAY, 8'h00, 16'd10, 1'b0}},
		'{8'hFF, 1'b0, NO_ITEM},
		'{8'hFF, 1'b1, '{KIND_END, 8'h00, 16'd0, 1'b0}},
		'{8'h55, 1'b1, '{KIND_CMD, 8'h55, 16'd0, 1'b0}},
		'{8'h02, 1'b0, NO_ITEM},
		'{8'hFF, 1'b0, NO_ITEM},
		'{8'hFF, 1'b1, '{KIND_PARAM, 8'hFF, 16'd0, 1'b1}},
		'{8'hFF, 1'b0, NO_ITEM},
		'{8'hFF, 1'b1, '{KIND_END, 8'h00, 16'd0, 1'b0}}
	};

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	byte_t cfg_wdata;

	lcdp_byte_if list_in();
	lcdp_item_if items();

	lcd_init_command_list_player_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.list_in   (list_in),
		.items     (items)
	);

	// Shadow parser state and the delay scale it multiplies by.
	parse_phase_e shadow_phase;
	byte_t        shadow_left;
	byte_t        shadow_scale;

	// Items that the list bytes sent so far must still produce, oldest first.
	item_t pending_items[$];

	// When throttle is low, neither side idles or stalls.
	logic throttle;

	int mismatches;
	int bytes_sent;
	int items_checked;
	int delays_seen;
	int ends_seen;
	int long_records;
	int stall_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Walks one list byte through the shadow parser. Returns 1 when the byte
	// produces an item, which is then placed in next_item.
	function automatic logic parse_list_byte(input byte_t b, output item_t next_item);
		next_item = NO_ITEM;
		case (shadow_phase)
			AWAIT_CMD: begin
				if (b == MARK_BYTE) begin
					shadow_phase = AWAIT_ARG;
					return 1'b0;
				end
				shadow_phase = AWAIT_COUNT;
				next_item.kind = KIND_CMD;
				next_item.value = b;
				return 1'b1;
			end
			AWAIT_COUNT: begin
				// The count byte loads the parameter counter and produces no item.
				shadow_left = b;
				shadow_phase = (b == 8'd0) ? AWAIT_CMD : IN_PARAMS;
				return 1'b0;
			end
			IN_PARAMS: begin
				next_item.kind = KIND_PARAM;
				next_item.value = b;
				if (shadow_left <= 8'd1) begin
					shadow_left = 8'd0;
					shadow_phase = AWAIT_CMD;
					next_item.last = 1'b1;
				end else begin
					shadow_left = shadow_left - 8'd1;
				end
				return 1'b1;
			end
			default: begin
				// Second byte of a pseudo-record: end marker or delay argument.
				shadow_phase = AWAIT_CMD;
				if (b == MARK_BYTE) begin
					next_item.kind = KIND_END;
				end else begin
					next_item.kind = KIND_DELAY;
					next_item.wait_ms = ms_t'(b) * ms_t'(shadow_scale);
				end
				return 1'b1;
			end
		endcase
	endfunction

	// Offers one list byte and returns in the time step of the edge at which it
	// was taken. Random idle cycles go in front of the beat while throttle is
	// high. The parser shadow is stepped only once the beat has happened; a
	// pinned row replaces the shadow's item with its own.
	task automatic offer_byte(input byte_t b, input logic pinned, input item_t pinned_item);
		item_t next_item;
		logic  produces;
		while (throttle && $urandom_range(99) < 35) begin
			list_in.valid <= 1'b0;
			@(posedge clk);
		end
		list_in.valid <= 1'b1;
		list_in.list_byte <= b;
		do @(posedge clk); while (list_in.ready !== 1'b1);
		bytes_sent++;
		produces = parse_list_byte(b, next_item);
		if (pinned)
			pending_items.push_back(pinned_item);
		else if (produces)
			pending_items.push_back(next_item);
	endtask

	task automatic offer_plain(input byte_t b);
		offer_byte(b, 1'b0, NO_ITEM);
	endtask

	// Stops the sender and waits until every outstanding item has been taken.
	// Some bytes leave no item behind, so the pipeline may still be busy with
	// one of them; the task lets it settle before anything else happens.
	task automatic drain_items();
		list_in.valid <= 1'b0;
		while (pending_items.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The scale may only change while nothing is in flight.
	task automatic set_scale(input byte_t scale);
		drain_items();
		cfg_we <= 1'b1;
		cfg_wdata <= scale;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_scale = scale;
	endtask

	// Returns a byte that is never 0xFF, biased toward the ends of its range.
	function automatic byte_t plain_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFE;
			2: return 8'h01;
			default: return byte_t'($urandom_range(254));
		endcase
	endfunction

	// Sends mostly well-formed records with random content, plus delays, end
	// markers and the odd stray byte that knocks the parser out of step. A
	// record may finish past the byte budget.
	task automatic play_random_list(input int budget);
		int    pick;
		int    count;
		int    stop_at;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 68) begin
				// A count of 255 costs a lot of bytes, so it is kept rare.
				if ($urandom_range(59) == 0) begin
					count = 255;
					long_records++;
				end else if ($urandom_range(9) == 0) begin
					count = $urandom_range(255, 0) % 40;
				end else begin
					count = $urandom_range(6);
				end
				offer_plain(plain_byte());
				offer_plain(byte_t'(count));
				repeat (count) offer_plain(byte_t'($urandom_range(255)));
			end else if (pick < 88) begin
				offer_plain(MARK_BYTE);
				offer_plain(plain_byte());
			end else if (pick < 94) begin
				offer_plain(MARK_BYTE);
				offer_plain(MARK_BYTE);
			end else begin
				offer_plain(byte_t'($urandom_range(255)));
			end
		end
	endtask

	task automatic report_mismatch(input string what, input item_t want, input item_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$write("tb: %s at %0t: want kind %0d value %02h wait %0d last %0b, ",
				what, $realtime, want.kind, want.value, want.wait_ms, want.last);
			$display("got kind %0d value %02h wait %0d last %0b",
				got.kind, got.value, got.wait_ms, got.last);
		end
	endtask

	// Item checker. Each beat on the item channel is matched against the oldest
	// outstanding expectation. The ready choice for the next edge is made here
	// too, so the receiver stalls at random while throttle is high.
	always @(posedge clk) begin
		item_t got;
		item_t want;
		if (arst_n && items.valid === 1'b1 && items.ready === 1'b1) begin
			got.kind = items.item_kind;
			got.value = items.byte_value;
			got.wait_ms = items.wait_ms;
			got.last = items.last_param;
			if (pending_items.size() == 0) begin
				report_mismatch("unexpected item", NO_ITEM, got);
			end else begin
				want = pending_items.pop_front();
				items_checked++;
				if (want.kind == KIND_DELAY)
					delays_seen++;
				if (want.kind == KIND_END)
					ends_seen++;
				if (got.kind !== want.kind || got.value !== want.value ||
						got.wait_ms !== want.wait_ms || got.last !== want.last)
					report_mismatch("item mismatch", want, got);
			end
		end
		items.ready <= !throttle || ($urandom_range(99) >= 35);
	end

	// Watchdog: a run of cycles with no beat on either channel means the block
	// has hung. Every legitimate quiet spell is far shorter than the limit.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (list_in.valid === 1'b1 && list_in.ready === 1'b1) ||
					(items.valid === 1'b1 && items.ready === 1'b1))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		byte_t scale_plan [6];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		list_in.valid = 1'b0;
		list_in.list_byte = '0;
		items.ready = 1'b0;
		throttle = 1'b1;
		mismatches = 0;
		bytes_sent = 0;
		items_checked = 0;
		delays_seen = 0;
		ends_seen = 0;
		long_records = 0;
		shadow_phase = AWAIT_CMD;
		shadow_left = '0;
		shadow_scale = SCALE_RESET;

		// The scale walks through both ends of its range, a zero that the block
		// has to tolerate, and a few random values.
		scale_plan[0] = 8'd1;
		scale_plan[1] = 8'd255;
		scale_plan[2] = 8'd0;
		scale_plan[3] = byte_t'($urandom_range(255, 1));
		scale_plan[4] = byte_t'($urandom_range(255, 1));
		scale_plan[5] = byte_t'($urandom_range(255, 1));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed list first, under the reset scale.
		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_byte(DIRECTED[i].b, DIRECTED[i].pinned, DIRECTED[i].want);
		play_random_list(PHASE_BYTES);

		// One phase per scale setting. Every change drains the block first,
		// which also makes the sender wait for all outstanding items. One phase
		// runs with no idling on either side.
		for (int p = 0; p < 6; p++) begin
			set_scale(scale_plan[p]);
			throttle = (p != 1);
			play_random_list(PHASE_BYTES);
		end
		throttle = 1'b1;

		drain_items();

		$display("tb: %0d list bytes sent, %0d items checked (%0d delays, %0d end markers)",
			bytes_sent, items_checked, delays_seen, ends_seen);
		$display("tb: %0d records with 255 parameters, 7 delay scales, %0d mismatches",
			long_records, mismatches);
		if (mismatches == 0 && pending_items.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
